// File: hdl/cdgc_pkg.sv
// Shared types, constants and helper functions for the coil discharge gain capture block.
package cdgc_pkg;

  localparam int unsigned WINDOW     = 5;
  localparam int unsigned PTR_W      = $clog2(WINDOW);
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned RPM_W      = 14;
  localparam int unsigned RISE_W     = RPM_W + 1;
  localparam int unsigned TOTAL_W    = RISE_W + $clog2(WINDOW);
  localparam int unsigned THR_W      = 10;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);

  // floor(rpm / 100) is rpm * 10486 >> 20, exact for every 14-bit rpm.
  localparam int unsigned STEP_SHIFT = 20;
  localparam int unsigned STEP_MUL   = 10486;
  localparam int unsigned STEP_MUL_W = 14;
  localparam int unsigned STEP_PROD_W = RPM_W + STEP_MUL_W;

  typedef enum logic {
    CMD_SAMPLE  = 1'b0,
    CMD_COLLECT = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    COIL_DISCHARGED = 2'd0,
    COIL_PRIMED     = 2'd1,
    COIL_CHARGING   = 2'd2,
    COIL_OTHER      = 2'd3
  } coil_phase_e;

  typedef enum logic [1:0] {
    CAP_READY     = 2'd0,
    CAP_ACCEPTING = 2'd1,
    CAP_COMPLETED = 2'd2
  } cap_phase_e;

  typedef struct packed {
    command_e            command;
    logic [ANGLE_W-1:0]  crank_angle;
    logic [RPM_W-1:0]    engine_rpm;
    coil_phase_e         coil_phase;
  } item_t;

  typedef struct packed {
    logic [RPM_W-1:0]    speed_step;
    logic [ANGLE_W-1:0]  spark_angle;
    logic [RPM_W-1:0]    spark_rpm;
    logic [ANGLE_W-1:0]  rise_angle;
  } result_t;

  // Rounds an rpm down to a multiple of 100 without a divider.
  function automatic logic [RPM_W-1:0] step_floor(input logic [RPM_W-1:0] rpm);
    logic [STEP_PROD_W-1:0] prod;
    logic [RPM_W-1:0]       quo;
    logic [RPM_W+6:0]       scaled;
    prod   = STEP_PROD_W'(rpm) * STEP_PROD_W'(STEP_MUL);
    quo    = RPM_W'(prod >> STEP_SHIFT);
    // quo * 100 as quo * 64 + quo * 32 + quo * 4
    scaled = ((RPM_W+7)'(quo) << 6) + ((RPM_W+7)'(quo) << 5) + ((RPM_W+7)'(quo) << 2);
    return scaled[RPM_W-1:0];
  endfunction

endpackage

// File: hdl/cdgc_in_reg.sv
// Input register that holds one accepted item for the capture core.
module cdgc_in_reg
  import cdgc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign in_ready_o = !valid_q || pop_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hdl/cdgc_core.sv
// Capture state, rise and angle rings, and the combinational update for one item.
module cdgc_core
  import cdgc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  item_t            item_i,
  input  logic [THR_W-1:0] threshold_i,
  output logic             emit_o,
  output result_t          result_o
);

  cap_phase_e                 cap_q, cap_d;
  coil_phase_e                last_q, last_d;
  logic signed [RISE_W-1:0]   rise_ring_q [WINDOW];
  logic signed [RISE_W-1:0]   rise_ring_d [WINDOW];
  logic [ANGLE_W-1:0]         angle_ring_q [WINDOW];
  logic [ANGLE_W-1:0]         angle_ring_d [WINDOW];
  logic [PTR_W-1:0]           ptr_q, ptr_d;
  logic signed [TOTAL_W-1:0]  total_q, total_d;
  logic                       full_q, full_d;
  result_t                    held_q, held_d;

  cap_phase_e                 cap_eff;
  logic signed [RISE_W-1:0]   rise;
  logic signed [TOTAL_W-1:0]  total_new;
  logic signed [TOTAL_W-1:0]  limit;
  logic                       full_new;
  logic [PTR_W-1:0]           oldest;
  logic [PTR_W-1:0]           ptr_next;
  logic                       ptr_last;

  // mean = total / WINDOW truncated; mean > thr holds exactly when
  // total > WINDOW * thr + WINDOW - 1 (a negative total never passes).
  assign limit = TOTAL_W'(threshold_i) * TOTAL_W'(WINDOW) + TOTAL_W'(WINDOW - 1);

  assign rise      = $signed({1'b0, item_i.engine_rpm}) - $signed({1'b0, held_q.spark_rpm});
  assign total_new = total_q - TOTAL_W'(rise_ring_q[ptr_q]) + TOTAL_W'(rise);
  assign ptr_last  = (ptr_q == PTR_W'(WINDOW - 1));
  assign full_new  = full_q || ptr_last;
  assign oldest    = ptr_last ? '0 : ptr_q + PTR_W'(1);
  assign ptr_next  = ptr_last ? '0 : ptr_q + PTR_W'(1);

  assign cap_eff = (cap_q == CAP_READY && last_q == COIL_DISCHARGED &&
                    item_i.coil_phase == COIL_PRIMED) ? CAP_ACCEPTING : cap_q;

  always_comb begin
    cap_d        = cap_q;
    last_d       = last_q;
    rise_ring_d  = rise_ring_q;
    angle_ring_d = angle_ring_q;
    ptr_d        = ptr_q;
    total_d      = total_q;
    full_d       = full_q;
    held_d       = held_q;
    emit_o       = 1'b0;
    if (fire_i) begin
      case (item_i.command)
        CMD_COLLECT: begin
          if (cap_q == CAP_COMPLETED) begin
            emit_o = (held_q.speed_step != '0);
            cap_d  = CAP_READY;
            for (int k = 0; k < WINDOW; k++) begin
              rise_ring_d[k]  = '0;
              angle_ring_d[k] = '0;
            end
            ptr_d   = '0;
            total_d = '0;
            full_d  = 1'b0;
            held_d  = '0;
          end
        end
        CMD_SAMPLE: begin
          cap_d  = cap_eff;
          last_d = item_i.coil_phase;
          if (cap_eff == CAP_ACCEPTING) begin
            if (last_q == COIL_PRIMED && item_i.coil_phase == COIL_CHARGING) begin
              held_d.speed_step = step_floor(item_i.engine_rpm);
            end else if (item_i.coil_phase != COIL_DISCHARGED) begin
              // Only the last phase moves.
            end else if (last_q == COIL_CHARGING) begin
              held_d.spark_angle = item_i.crank_angle;
              held_d.spark_rpm   = item_i.engine_rpm;
            end else begin
              angle_ring_d[ptr_q] = item_i.crank_angle;
              rise_ring_d[ptr_q]  = rise;
              total_d             = total_new;
              full_d              = full_new;
              if (full_new && total_new > limit) begin
                held_d.rise_angle = angle_ring_q[oldest];
                cap_d             = CAP_COMPLETED;
                last_d            = last_q;
              end else begin
                ptr_d = ptr_next;
              end
            end
          end
        end
        default: begin
          cap_d = cap_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_READY;
      last_q  <= COIL_DISCHARGED;
      ptr_q   <= '0;
      total_q <= '0;
      full_q  <= 1'b0;
      held_q  <= '0;
      for (int k = 0; k < WINDOW; k++) begin
        rise_ring_q[k]  <= '0;
        angle_ring_q[k] <= '0;
      end
    end else begin
      cap_q        <= cap_d;
      last_q       <= last_d;
      ptr_q        <= ptr_d;
      total_q      <= total_d;
      full_q       <= full_d;
      held_q       <= held_d;
      rise_ring_q  <= rise_ring_d;
      angle_ring_q <= angle_ring_d;
    end
  end

  assign result_o = held_q;

endmodule

// File: hdl/coil_discharge_gain_capture.sv
// Top level of the coil discharge gain capture block: ports, threshold and result register.
// Path: a collect item accepted into the input register is handled by the single-pass
// update, which loads the result register once that register can take a result, so its
// result is offered from the result register (input register, then result register).
// Throughput: one item per cycle, limited only by the result register draining.
// Reset: asynchronous, active low; clears capture state, rings, held values and
// sets the mean rise threshold to 5. No clearing pass is needed.
module coil_discharge_gain_capture
  import cdgc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input item channel.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [ANGLE_W-1:0] crank_angle_i,
  input  logic [RPM_W-1:0]   engine_rpm_i,
  input  logic [1:0]         coil_phase_i,
  // Result item channel.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [RPM_W-1:0]   speed_step_o,
  output logic [ANGLE_W-1:0] spark_angle_o,
  output logic [RPM_W-1:0]   spark_rpm_o,
  output logic [ANGLE_W-1:0] rise_angle_o,
  // Threshold register write port.
  input  logic               cfg_we_i,
  input  logic [THR_W-1:0]   cfg_data_i
);

  item_t            in_item;
  item_t            cur_item;
  logic             cur_valid;
  logic             fire;
  logic             emit;
  result_t          core_result;

  logic [THR_W-1:0] thr_q;
  logic             out_valid_q, out_valid_d;
  result_t          out_q;

  assign in_item.command     = command_e'(command_i);
  assign in_item.crank_angle = crank_angle_i;
  assign in_item.engine_rpm  = engine_rpm_i;
  assign in_item.coil_phase  = coil_phase_e'(coil_phase_i);

  // The held item is processed whenever the result register can take a result,
  // so a waiting result never lets a new one overwrite it.
  assign fire = cur_valid && (!out_valid_q || out_ready_i);

  cdgc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .pop_i      (fire),
    .valid_o    (cur_valid),
    .item_o     (cur_item)
  );

  cdgc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (cur_item),
    .threshold_i (thr_q),
    .emit_o      (emit),
    .result_o    (core_result)
  );

  // The result is taken from the held values before the collect clears them.
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= THR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_q <= core_result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign speed_step_o  = out_q.speed_step;
  assign spark_angle_o = out_q.spark_angle;
  assign spark_rpm_o   = out_q.spark_rpm;
  assign rise_angle_o  = out_q.rise_angle;

endmodule
